// ===== hdl/fac_pkg.sv =====
// Shared types and constants for the frustum/box cull test block.
package fac_pkg;
	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 16;
	localparam int NUM_PLANES  = 6;
	localparam int NUM_CORNERS = 8;
	localparam int SLOT_W      = 3;
	localparam int PROD_W      = 2 * COORD_WIDTH;
	localparam int SUM_W       = PROD_W + 2;

	localparam logic [1:0] OP_LOAD_PLANE  = 2'd0;
	localparam logic [1:0] OP_LOAD_CORNER = 2'd1;
	localparam logic [1:0] OP_TEST_BOX    = 2'd2;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic [SLOT_W-1:0] slot_t;

	typedef struct packed {
		coord_t a;
		coord_t b;
		coord_t c;
		coord_t d;
	} plane_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} corner_t;

	// controller -> datapath
	typedef struct packed {
		logic  we_plane;
		logic  we_corner;
		logic  start;
		logic  issue;
		slot_t addr;
	} fac_cmd_t;
endpackage

// ===== hdl/fac_in_if.sv =====
// Input channel: load and test transactions.
interface fac_in_if;
	import fac_pkg::*;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	slot_t      slot;
	coord_t     coef_a, coef_b, coef_c, coef_d;
	coord_t     min_x, min_y, min_z, max_x, max_y, max_z;
	modport source(output valid, op, slot, coef_a, coef_b, coef_c, coef_d,
		min_x, min_y, min_z, max_x, max_y, max_z, input ready);
	modport sink(input valid, op, slot, coef_a, coef_b, coef_c, coef_d,
		min_x, min_y, min_z, max_x, max_y, max_z, output ready);
endinterface

// ===== hdl/fac_out_if.sv =====
// Output channel: one inside flag per test.
interface fac_out_if;
	logic valid;
	logic ready;
	logic inside_res;
	modport source(output valid, inside_res, input ready);
	modport sink(input valid, inside_res, output ready);
endinterface

// ===== hdl/fac_ctrl.sv =====
// Sequencer: loads, eight-step test sweep, drain and result handshake.
module fac_ctrl import fac_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic [1:0] in_op,
	input  slot_t    in_slot,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output fac_cmd_t cmd
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0] state_q;
	slot_t      cnt_q;
	logic       drain_q;
	logic       acc;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign acc       = in_valid && in_ready;

	always_comb begin
		cmd.we_plane  = acc && (in_op == OP_LOAD_PLANE) && (in_slot < SLOT_W'(NUM_PLANES));
		cmd.we_corner = acc && (in_op == OP_LOAD_CORNER);
		cmd.start     = acc && (in_op == OP_TEST_BOX);
		cmd.issue     = (state_q == ST_RUN);
		cmd.addr      = (state_q == ST_RUN) ? cnt_q : in_slot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			drain_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						state_q <= ST_RUN;
						cnt_q   <= '0;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == SLOT_W'(NUM_CORNERS - 1)) begin
						state_q <= ST_WAIT;
						drain_q <= 1'b0;
					end
				end
				ST_WAIT: begin
					// drain: memory read, then multiply
					drain_q <= 1'b1;
					if (drain_q) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== hdl/fac_dp.sv =====
// Datapath: plane and corner stores, plane dot products, corner bound checks.
module fac_dp import fac_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  fac_cmd_t cmd,
	input  coord_t   coef_a, coef_b, coef_c, coef_d,
	input  coord_t   min_x, min_y, min_z, max_x, max_y, max_z,
	output logic     inside_res
);
	plane_t  plane_mem [NUM_PLANES];
	corner_t corner_mem [NUM_CORNERS];

	plane_t  plane_s1;
	corner_t corner_s1;
	logic    v_s1, pl_ok_s1;
	logic signed [PROD_W-1:0] px_s2, py_s2, pz_s2;
	coord_t  d_s2;
	logic    v_s2;

	coord_t  bmin_q [3];
	coord_t  bmax_q [3];
	logic [2:0] above_q, below_q;
	logic    culled_q;

	coord_t  sx, sy, sz;
	logic signed [SUM_W-1:0] sum;
	logic signed [SUM_W-1:0] d_ext;

	always_ff @(posedge clk) begin
		if (cmd.we_plane)
			plane_mem[cmd.addr] <= '{coef_a, coef_b, coef_c, coef_d};
		if (cmd.we_corner)
			corner_mem[cmd.addr] <= '{coef_a, coef_b, coef_c};
		if (cmd.issue) begin
			if (cmd.addr < SLOT_W'(NUM_PLANES)) plane_s1 <= plane_mem[cmd.addr];
			corner_s1 <= corner_mem[cmd.addr];
		end
		if (cmd.start) begin
			bmin_q <= '{min_x, min_y, min_z};
			bmax_q <= '{max_x, max_y, max_z};
		end
		px_s2 <= PROD_W'(plane_s1.a) * PROD_W'(sx);
		py_s2 <= PROD_W'(plane_s1.b) * PROD_W'(sy);
		pz_s2 <= PROD_W'(plane_s1.c) * PROD_W'(sz);
		d_s2  <= plane_s1.d;
	end

	// per axis, the box corner that maximizes the plane value; bounds may be swapped
	assign sx = (plane_s1.a[COORD_WIDTH-1] ^ (bmax_q[0] < bmin_q[0])) ? bmin_q[0] : bmax_q[0];
	assign sy = (plane_s1.b[COORD_WIDTH-1] ^ (bmax_q[1] < bmin_q[1])) ? bmin_q[1] : bmax_q[1];
	assign sz = (plane_s1.c[COORD_WIDTH-1] ^ (bmax_q[2] < bmin_q[2])) ? bmin_q[2] : bmax_q[2];

	assign d_ext = SUM_W'(d_s2);
	assign sum   = SUM_W'(px_s2) + SUM_W'(py_s2) + SUM_W'(pz_s2) + (d_ext <<< FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			pl_ok_s1 <= 1'b0;
			v_s2     <= 1'b0;
			above_q  <= '0;
			below_q  <= '0;
			culled_q <= 1'b0;
		end else begin
			v_s1     <= cmd.issue;
			pl_ok_s1 <= cmd.issue && (cmd.addr < SLOT_W'(NUM_PLANES));
			v_s2     <= pl_ok_s1;
			if (cmd.start) begin
				above_q  <= '1;
				below_q  <= '1;
				culled_q <= 1'b0;
			end else begin
				if (v_s1) begin
					above_q <= above_q & {bmax_q[2] < corner_s1.z,
						bmax_q[1] < corner_s1.y, bmax_q[0] < corner_s1.x};
					below_q <= below_q & {corner_s1.z < bmin_q[2],
						corner_s1.y < bmin_q[1], corner_s1.x < bmin_q[0]};
				end
				if (v_s2 && sum[SUM_W-1]) culled_q <= 1'b1;
			end
		end
	end

	assign inside_res = !(culled_q || (|above_q) || (|below_q));
endmodule

// ===== hdl/frustum_aabb_cull_test.sv =====
// Top level: frustum/box cull test with plane and corner stores.
//  channel | dir | payload
//  req     | in  | op, slot, coef_a..coef_d, min_x..max_z
//  rsp     | out | inside_res (tests only)
// Loads give no transaction on rsp.
// A test sweeps eight store addresses, one corner per cycle and a plane at each
// of the six plane slots, then drains (store read, multiply) before rsp is valid.
// req is held off from a test accept until its result transaction completes.
// Reset clears control only; stores hold garbage until loaded.
module frustum_aabb_cull_test import fac_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	fac_in_if.sink   req,
	fac_out_if.source rsp
);
	fac_cmd_t cmd;

	fac_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_op(req.op), .in_slot(req.slot),
		.in_ready(req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready),
		.cmd(cmd)
	);

	fac_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.coef_a(req.coef_a), .coef_b(req.coef_b), .coef_c(req.coef_c), .coef_d(req.coef_d),
		.min_x(req.min_x), .min_y(req.min_y), .min_z(req.min_z),
		.max_x(req.max_x), .max_y(req.max_y), .max_z(req.max_z),
		.inside_res(rsp.inside_res)
	);

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !req.ready) else $error("input open while result pending");
	a_test_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> !req.ready && !rsp.valid) else $error("test did not start sweep");
	a_rsp_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.ready |=> req.ready && !rsp.valid) else $error("no return to idle");
`endif
endmodule

// ===== tb/fac_tb_if.sv =====
// Testbench package: request record for the input channel.
package fac_tb_pkg;
	import fac_pkg::*;
	typedef struct {
		logic [1:0] op;
		slot_t      slot;
		coord_t     coef_a, coef_b, coef_c, coef_d;
		coord_t     min_x, min_y, min_z, max_x, max_y, max_z;
	} cull_req_t;
endpackage

// ===== tb/tb.sv =====
// Testbench for the frustum/box cull test block: directed and random transactions.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import fac_pkg::*;
	import fac_tb_pkg::*;

	localparam logic [1:0] OP_IGNORED = 2'd3;

	logic clk;
	logic arst_n;
	fac_in_if  req();
	fac_out_if rsp();

	frustum_aabb_cull_test u_dut(.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	// shadow stores
	coord_t plane_mem [NUM_PLANES][4];
	coord_t corner_mem [NUM_CORNERS][3];
	logic   inside_q [$];
	int     errors = 0;
	int     hold_cycles = 0;
	int     results_seen = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#100ms;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic logic plane_below(int p, coord_t x, coord_t y, coord_t z);
		logic signed [127:0] acc;
		acc = $signed(plane_mem[p][0]) * $signed(x)
			+ $signed(plane_mem[p][1]) * $signed(y)
			+ $signed(plane_mem[p][2]) * $signed(z)
			+ $signed(plane_mem[p][3]) * $signed(128'sd65536);
		return acc < 0;
	endfunction

	function automatic logic box_inside(cull_req_t r);
		coord_t lo [3];
		coord_t hi [3];
		int neg, above, below;
		lo = '{r.min_x, r.min_y, r.min_z};
		hi = '{r.max_x, r.max_y, r.max_z};
		for (int p = 0; p < NUM_PLANES; p++) begin
			neg = 0;
			for (int q = 0; q < 8; q++)
				if (plane_below(p, q[0] ? hi[0] : lo[0], q[1] ? hi[1] : lo[1],
						q[2] ? hi[2] : lo[2]))
					neg++;
			if (neg == 8)
				return 1'b0;
		end
		for (int k = 0; k < 3; k++) begin
			above = 0;
			below = 0;
			for (int q = 0; q < NUM_CORNERS; q++) begin
				if (hi[k] < corner_mem[q][k]) above++;
				if (corner_mem[q][k] < lo[k]) below++;
			end
			if (above == NUM_CORNERS || below == NUM_CORNERS)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic void predict(cull_req_t r);
		case (r.op)
			OP_LOAD_PLANE:
				if (r.slot < NUM_PLANES)
					plane_mem[r.slot] = '{r.coef_a, r.coef_b, r.coef_c, r.coef_d};
			OP_LOAD_CORNER: corner_mem[r.slot] = '{r.coef_a, r.coef_b, r.coef_c};
			OP_TEST_BOX: inside_q.push_back(box_inside(r));
			default: ;
		endcase
	endfunction

	function automatic int gap_len();
		int g;
		g = $urandom_range(0, 99);
		if (g < 50) return 0;
		if (g < 92) return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	// valid stays high after an accept unless a gap follows
	task automatic send(cull_req_t r);
		int g;
		g = gap_len();
		if (g > 0) begin
			req.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		req.valid  <= 1'b1;
		req.op     <= r.op;
		req.slot   <= r.slot;
		req.coef_a <= r.coef_a;
		req.coef_b <= r.coef_b;
		req.coef_c <= r.coef_c;
		req.coef_d <= r.coef_d;
		req.min_x  <= r.min_x;
		req.min_y  <= r.min_y;
		req.min_z  <= r.min_z;
		req.max_x  <= r.max_x;
		req.max_y  <= r.max_y;
		req.max_z  <= r.max_z;
		do @(posedge clk); while (!req.ready);
		predict(r);
	endtask

	// receiver: random stalls, plus a long hold-off when requested
	initial begin
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				rsp.ready <= 1'b0;
			end else
				rsp.ready <= ($urandom_range(0, 9) < 7) ||
					($urandom_range(0, 50) == 0 ? 1'b0 : 1'b1) && $urandom_range(0, 1);
		end
	end

	// result checker
	initial begin
		logic exp_inside;
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready) begin
				results_seen++;
				if (inside_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual inside_res=%0b",
						$time, rsp.inside_res);
					errors++;
				end else begin
					exp_inside = inside_q.pop_front();
					if (rsp.inside_res !== exp_inside) begin
						$display("%0t: inside_res mismatch, expected %0b, actual %0b",
							$time, exp_inside, rsp.inside_res);
						errors++;
					end
				end
			end
		end
	end

	function automatic coord_t rnd_coord();
		case ($urandom_range(0, 7))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return '0;
			3: return coord_t'($urandom);
			default: return coord_t'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
		endcase
	endfunction

	function automatic cull_req_t rnd_item(logic [1:0] op);
		cull_req_t r;
		r.op = op;
		r.slot = slot_t'($urandom_range(0, 7));
		r.coef_a = rnd_coord();
		r.coef_b = rnd_coord();
		r.coef_c = rnd_coord();
		r.coef_d = rnd_coord();
		r.min_x = rnd_coord();
		r.min_y = rnd_coord();
		r.min_z = rnd_coord();
		r.max_x = rnd_coord();
		r.max_y = rnd_coord();
		r.max_z = rnd_coord();
		// mostly well-ordered boxes so the plane tests matter
		if ($urandom_range(0, 9) < 8) begin
			if (r.min_x > r.max_x) {r.min_x, r.max_x} = {r.max_x, r.min_x};
			if (r.min_y > r.max_y) {r.min_y, r.max_y} = {r.max_y, r.min_y};
			if (r.min_z > r.max_z) {r.min_z, r.max_z} = {r.max_z, r.min_z};
		end
		return r;
	endfunction

	task automatic load_all_random();
		cull_req_t r;
		for (int p = 0; p < NUM_PLANES; p++) begin
			r = rnd_item(OP_LOAD_PLANE);
			r.slot = slot_t'(p);
			send(r);
		end
		for (int q = 0; q < NUM_CORNERS; q++) begin
			r = rnd_item(OP_LOAD_CORNER);
			r.slot = slot_t'(q);
			send(r);
		end
	endtask

	// unit cube frustum: planes x>=-1 etc., corners at +-1
	task automatic test_directed();
		cull_req_t r;
		coord_t one = 32'sh0001_0000;
		for (int p = 0; p < NUM_PLANES; p++) begin
			r = rnd_item(OP_LOAD_PLANE);
			r.slot = slot_t'(p);
			r.coef_a = (p == 0) ? one : (p == 1) ? -one : '0;
			r.coef_b = (p == 2) ? one : (p == 3) ? -one : '0;
			r.coef_c = (p == 4) ? one : (p == 5) ? -one : '0;
			r.coef_d = one;
			send(r);
		end
		for (int q = 0; q < NUM_CORNERS; q++) begin
			r = rnd_item(OP_LOAD_CORNER);
			r.slot = slot_t'(q);
			r.coef_a = q[0] ? one : -one;
			r.coef_b = q[1] ? one : -one;
			r.coef_c = q[2] ? one : -one;
			send(r);
		end
		// ignored plane slots and ignored op
		r = rnd_item(OP_LOAD_PLANE); r.slot = 3'd6; send(r);
		r = rnd_item(OP_LOAD_PLANE); r.slot = 3'd7; send(r);
		r = rnd_item(OP_IGNORED); send(r);
		// box inside, box one unit outside, box far out, full-range box in both bound orders, inverted box
		r = rnd_item(OP_TEST_BOX);
		{r.min_x, r.min_y, r.min_z} = {3{-one}};
		{r.max_x, r.max_y, r.max_z} = {3{one}};
		send(r);
		r.min_x = 32'sh0002_0000; r.max_x = 32'sh0002_0000; send(r);
		r.min_x = 32'sh0002_0001; r.max_x = 32'sh7fff_ffff; send(r);
		r.min_x = 32'sh7fff_ffff; r.max_x = 32'sh8000_0000; send(r);
		r.min_x = 32'sh8000_0000; r.max_x = 32'sh7fff_ffff; send(r);
		r.min_x = one; r.max_x = -one; send(r);
	endtask

	task automatic test_random(int n);
		int pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) send(rnd_item(OP_LOAD_PLANE));
			else if (pick < 15) send(rnd_item(OP_LOAD_CORNER));
			else if (pick < 17) send(rnd_item(OP_IGNORED));
			else send(rnd_item(OP_TEST_BOX));
		end
	endtask

	// receiver stalls long while tests keep coming
	task automatic test_backpressure();
		hold_cycles = 200;
		test_random(40);
	endtask

	initial begin
		req.valid = 1'b0;
		req.op = OP_LOAD_PLANE;
		req.slot = '0;
		{req.coef_a, req.coef_b, req.coef_c, req.coef_d} = '0;
		{req.min_x, req.min_y, req.min_z, req.max_x, req.max_y, req.max_z} = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		load_all_random();
		test_backpressure();
		test_random(1850);
		req.valid <= 1'b0;
		while (inside_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

// ===== frustum_aabb_cull_test.f =====
hdl/fac_pkg.sv
hdl/fac_in_if.sv
hdl/fac_out_if.sv
hdl/fac_ctrl.sv
hdl/fac_dp.sv
hdl/frustum_aabb_cull_test.sv
tb/fac_tb_if.sv
tb/tb.sv
